FILE: rtl/jst_pkg.sv
package jst_pkg;

  // Table sizing
  localparam int MAX_JOBS = 64;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);

  // Operation codes
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_READY  = 3'd1;
  localparam logic [2:0] ACT_CANCEL = 3'd2;
  localparam logic [2:0] ACT_REEVAL = 3'd3;
  localparam logic [2:0] ACT_REMOVE = 3'd4;
  localparam logic [2:0] ACT_READ   = 3'd5;

  // Job lifecycle states
  localparam logic [2:0] JS_SUBMITTED = 3'd0;
  localparam logic [2:0] JS_READY     = 3'd1;
  localparam logic [2:0] JS_RUNNING   = 3'd2;
  localparam logic [2:0] JS_COMPLETED = 3'd3;
  localparam logic [2:0] JS_PARTIAL   = 3'd4;
  localparam logic [2:0] JS_FAILED    = 3'd5;
  localparam logic [2:0] JS_CANCELLED = 3'd6;

  // Result status codes
  localparam logic [1:0] RS_OK          = 2'd0;
  localparam logic [1:0] RS_NOT_FOUND   = 2'd1;
  localparam logic [1:0] RS_WRONG_STATE = 2'd2;
  localparam logic [1:0] RS_FULL        = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] job_ref;
    logic [31:0] client_tag;
    logic [47:0] now_time;
    logic [15:0] tasks_total;
    logic [15:0] tasks_done;
    logic [15:0] tasks_failed;
    logic [15:0] tasks_assigned;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] job_number;
    logic [2:0]  job_state;
    logic [31:0] client_owner;
    logic [47:0] submit_time;
    logic [47:0] start_time;
    logic [47:0] finish_time;
  } result_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] owner;
    logic [2:0]  state;
    logic [47:0] submitted;
    logic [47:0] started;
    logic [47:0] finished;
  } entry_t;

  // Table port request: one write and one registered read per cycle
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEARCH,
    S_APPLY,
    S_REM_RD,
    S_REM_WR
  } seq_state_t;

  function automatic logic is_final(input logic [2:0] st);
    return (st == JS_COMPLETED) || (st == JS_PARTIAL) ||
           (st == JS_FAILED) || (st == JS_CANCELLED);
  endfunction

  function automatic result_t make_result(input logic [1:0] status, input entry_t e);
    result_t r;
    r.status       = status;
    r.job_number   = e.id;
    r.job_state    = e.state;
    r.client_owner = e.owner;
    r.submit_time  = e.submitted;
    r.start_time   = e.started;
    r.finish_time  = e.finished;
    return r;
  endfunction

  function automatic result_t empty_result(input logic [1:0] status);
    result_t r;
    r        = '0;
    r.status = status;
    return r;
  endfunction

endpackage

FILE: rtl/jst_mem.sv
module jst_mem (
  input  logic              clk,
  input  jst_pkg::mem_req_t req,
  output jst_pkg::entry_t   rdata
);

  jst_pkg::entry_t mem [jst_pkg::MAX_JOBS];

  // Write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: rtl/jst_seq.sv
module jst_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  jst_pkg::cmd_t      cmd_in,
  output logic               busy,
  output logic               res_valid,
  output jst_pkg::result_t   res,
  output jst_pkg::mem_req_t  req,
  input  jst_pkg::entry_t    rdata
);

  jst_pkg::seq_state_t state, state_next;

  jst_pkg::cmd_t                cmd;
  logic [jst_pkg::CNT_W-1:0]    used_count;
  logic [31:0]                  next_id;
  logic [jst_pkg::CNT_W-1:0]    idx;
  logic                         cmp_valid;
  logic [jst_pkg::IDX_W-1:0]    cmp_idx;
  logic [jst_pkg::IDX_W-1:0]    slot;
  jst_pkg::entry_t              ent;

  logic                         full;
  logic                         bad_action;
  logic                         match;
  logic                         issue;
  logic                         last_is_slot;
  jst_pkg::entry_t              add_ent;
  jst_pkg::entry_t              upd_ent;
  logic [1:0]                   upd_status;
  logic [16:0]                  final_sum;

  assign busy = (state != jst_pkg::S_IDLE);

  // Search and dispatch decisions
  assign full       = (used_count >= jst_pkg::CNT_W'(jst_pkg::MAX_JOBS)) || (next_id == 32'd0);
  assign bad_action = (cmd.action > jst_pkg::ACT_READ);
  assign match      = cmp_valid && (rdata.id == cmd.job_ref);
  assign issue      = (idx < used_count);
  assign last_is_slot = (used_count - jst_pkg::CNT_W'(1)) == {1'b0, slot};

  // New entry on add
  always_comb begin
    add_ent.id        = next_id;
    add_ent.owner     = cmd.client_tag;
    add_ent.state     = jst_pkg::JS_SUBMITTED;
    add_ent.submitted = cmd.now_time;
    add_ent.started   = '0;
    add_ent.finished  = '0;
  end

  // State update of a found entry
  assign final_sum = {1'b0, cmd.tasks_done} + {1'b0, cmd.tasks_failed};

  always_comb begin
    upd_ent    = ent;
    upd_status = jst_pkg::RS_OK;
    unique case (cmd.action)
      jst_pkg::ACT_READY: begin
        if (ent.state != jst_pkg::JS_SUBMITTED) begin
          upd_status = jst_pkg::RS_WRONG_STATE;
        end else begin
          upd_ent.state = jst_pkg::JS_READY;
        end
      end
      jst_pkg::ACT_CANCEL: begin
        if (jst_pkg::is_final(ent.state)) begin
          upd_status = jst_pkg::RS_WRONG_STATE;
        end else begin
          upd_ent.state    = jst_pkg::JS_CANCELLED;
          upd_ent.finished = cmd.now_time;
        end
      end
      jst_pkg::ACT_REEVAL: begin
        if ((ent.state != jst_pkg::JS_CANCELLED) && (cmd.tasks_total != 16'd0)) begin
          if (final_sum == {1'b0, cmd.tasks_total}) begin
            priority if (cmd.tasks_failed == 16'd0) begin
              upd_ent.state = jst_pkg::JS_COMPLETED;
            end else if (cmd.tasks_done == 16'd0) begin
              upd_ent.state = jst_pkg::JS_FAILED;
            end else begin
              upd_ent.state = jst_pkg::JS_PARTIAL;
            end
            if (!jst_pkg::is_final(ent.state)) begin
              upd_ent.finished = cmd.now_time;
            end
          end else if ((cmd.tasks_assigned != 16'd0) &&
                       ((ent.state == jst_pkg::JS_READY) ||
                        (ent.state == jst_pkg::JS_SUBMITTED))) begin
            upd_ent.state = jst_pkg::JS_RUNNING;
            if (ent.started == 48'd0) begin
              upd_ent.started = cmd.now_time;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      jst_pkg::S_IDLE: begin
        if (start) state_next = jst_pkg::S_DISPATCH;
      end
      jst_pkg::S_DISPATCH: begin
        if ((cmd.action == jst_pkg::ACT_ADD) || bad_action || (cmd.job_ref == 32'd0)) begin
          state_next = jst_pkg::S_IDLE;
        end else begin
          state_next = jst_pkg::S_SEARCH;
        end
      end
      jst_pkg::S_SEARCH: begin
        priority if (match) state_next = jst_pkg::S_APPLY;
        else if (!issue)    state_next = jst_pkg::S_IDLE;
        else                state_next = jst_pkg::S_SEARCH;
      end
      jst_pkg::S_APPLY: begin
        if ((cmd.action == jst_pkg::ACT_REMOVE) && !last_is_slot) begin
          state_next = jst_pkg::S_REM_RD;
        end else begin
          state_next = jst_pkg::S_IDLE;
        end
      end
      jst_pkg::S_REM_RD: state_next = jst_pkg::S_REM_WR;
      jst_pkg::S_REM_WR: state_next = jst_pkg::S_IDLE;
      default:           state_next = jst_pkg::S_IDLE;
    endcase
  end

  // Outputs: table port and result beat
  always_comb begin
    req       = '0;
    res_valid = 1'b0;
    res       = '0;
    unique case (state)
      jst_pkg::S_DISPATCH: begin
        priority if (cmd.action == jst_pkg::ACT_ADD) begin
          res_valid = 1'b1;
          if (full) begin
            res = jst_pkg::empty_result(jst_pkg::RS_FULL);
          end else begin
            req.we    = 1'b1;
            req.waddr = used_count[jst_pkg::IDX_W-1:0];
            req.wdata = add_ent;
            res       = jst_pkg::make_result(jst_pkg::RS_OK, add_ent);
          end
        end else if (bad_action) begin
          res_valid = 1'b1;
          res       = jst_pkg::empty_result(jst_pkg::RS_WRONG_STATE);
        end else if (cmd.job_ref == 32'd0) begin
          res_valid = 1'b1;
          res       = jst_pkg::empty_result(jst_pkg::RS_NOT_FOUND);
        end else begin
        end
      end
      jst_pkg::S_SEARCH: begin
        if (!match) begin
          if (issue) begin
            req.re    = 1'b1;
            req.raddr = idx[jst_pkg::IDX_W-1:0];
          end else begin
            res_valid = 1'b1;
            res       = jst_pkg::empty_result(jst_pkg::RS_NOT_FOUND);
          end
        end
      end
      jst_pkg::S_APPLY: begin
        res_valid = 1'b1;
        if (cmd.action == jst_pkg::ACT_REMOVE) begin
          res = jst_pkg::make_result(jst_pkg::RS_OK, ent);
        end else begin
          res = jst_pkg::make_result(upd_status, upd_ent);
          if ((upd_status == jst_pkg::RS_OK) &&
              ((cmd.action == jst_pkg::ACT_READY) || (cmd.action == jst_pkg::ACT_CANCEL) ||
               (cmd.action == jst_pkg::ACT_REEVAL))) begin
            req.we    = 1'b1;
            req.waddr = slot;
            req.wdata = upd_ent;
          end
        end
      end
      jst_pkg::S_REM_RD: begin
        // used_count already points at the old last entry
        req.re    = 1'b1;
        req.raddr = used_count[jst_pkg::IDX_W-1:0];
      end
      jst_pkg::S_REM_WR: begin
        req.we    = 1'b1;
        req.waddr = slot;
        req.wdata = rdata;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= jst_pkg::S_IDLE;
      used_count <= '0;
      next_id    <= 32'd1;
      cmp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        jst_pkg::S_DISPATCH: begin
          cmp_valid <= 1'b0;
          if ((cmd.action == jst_pkg::ACT_ADD) && !full) begin
            used_count <= used_count + jst_pkg::CNT_W'(1);
            next_id    <= next_id + 32'd1;
          end
        end
        jst_pkg::S_SEARCH: begin
          cmp_valid <= issue && !match;
        end
        jst_pkg::S_APPLY: begin
          if (cmd.action == jst_pkg::ACT_REMOVE) begin
            used_count <= used_count - jst_pkg::CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      jst_pkg::S_IDLE: begin
        if (start) cmd <= cmd_in;
      end
      jst_pkg::S_DISPATCH: begin
        idx <= '0;
      end
      jst_pkg::S_SEARCH: begin
        if (match) begin
          ent  <= rdata;
          slot <= cmp_idx;
        end else if (issue) begin
          idx     <= idx + jst_pkg::CNT_W'(1);
          cmp_idx <= idx[jst_pkg::IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/job_status_table.sv
// Channel   Ports               Beat
// -------   -----------------   ----------------------------------------
// command   start, busy, cmd    taken at an edge with start high, busy low
// result    done, result        one cycle with done high, always taken
//
// Add, full, unknown-code and zero-reference commands answer from the dispatch
// state through the done/result registers. A lookup scans one entry per cycle
// through the registered read port; a hit answers from the apply state, a miss
// from search. Remove of any slot but the last stays busy to move the last entry
// into the freed slot. Reset clears the job count and sets the next job number
// to one; the table memory is not cleared. The result side has no backpressure.
module job_status_table (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  jst_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output jst_pkg::result_t result
);

  jst_pkg::mem_req_t req;
  jst_pkg::entry_t   rdata;
  logic              res_valid;
  jst_pkg::result_t  res;

  jst_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd_in    (cmd),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .req       (req),
    .rdata     (rdata)
  );

  jst_mem u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

  // Result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      result <= res;
    end
  end

endmodule

FILE: tb/job_table_checker.sv
`timescale 1ns / 1ps

module job_table_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  jst_pkg::cmd_t    cmd,
  input  logic             done,
  input  jst_pkg::result_t result,
  output int               fail_count,
  output int               pending
);

  // shadow copy of the job table
  jst_pkg::entry_t job_slots [jst_pkg::MAX_JOBS];
  int unsigned     job_count;
  logic [31:0]     next_number;

  // predicted result beats, oldest first
  jst_pkg::result_t awaited_results[$];
  jst_pkg::result_t want;
  int               beat_count;

  initial begin
    fail_count = 0;
    pending    = 0;
    beat_count = 0;
  end

  function automatic logic job_closed(input logic [2:0] st);
    return st == jst_pkg::JS_COMPLETED || st == jst_pkg::JS_PARTIAL ||
           st == jst_pkg::JS_FAILED || st == jst_pkg::JS_CANCELLED;
  endfunction

  // result fields for a slot; slot < 0 gives all-zero fields but the status
  function automatic jst_pkg::result_t slot_view(input logic [1:0] status, input int slot);
    jst_pkg::result_t r;
    r        = '0;
    r.status = status;
    if (slot >= 0) begin
      r.job_number   = job_slots[slot].id;
      r.job_state    = job_slots[slot].state;
      r.client_owner = job_slots[slot].owner;
      r.submit_time  = job_slots[slot].submitted;
      r.start_time   = job_slots[slot].started;
      r.finish_time  = job_slots[slot].finished;
    end
    return r;
  endfunction

  function automatic int find_slot(input logic [31:0] job_no);
    if (job_no == 32'd0) return -1;
    for (int i = 0; i < int'(job_count); i++) begin
      if (job_slots[i].id == job_no) return i;
    end
    return -1;
  endfunction

  // apply one command to the shadow table, return the result it must produce
  function automatic jst_pkg::result_t apply_job_command(input jst_pkg::cmd_t c);
    int               slot;
    logic [2:0]       st;
    logic [16:0]      closed_tasks;
    jst_pkg::result_t r;
    if (c.action == jst_pkg::ACT_ADD) begin
      if (job_count >= jst_pkg::MAX_JOBS || next_number == 32'd0) begin
        return slot_view(jst_pkg::RS_FULL, -1);
      end
      slot = int'(job_count);
      job_slots[slot].id        = next_number;
      job_slots[slot].owner     = c.client_tag;
      job_slots[slot].state     = jst_pkg::JS_SUBMITTED;
      job_slots[slot].submitted = c.now_time;
      job_slots[slot].started   = '0;
      job_slots[slot].finished  = '0;
      job_count++;
      next_number++;
      return slot_view(jst_pkg::RS_OK, slot);
    end
    if (c.action > jst_pkg::ACT_READ) return slot_view(jst_pkg::RS_WRONG_STATE, -1);

    slot = find_slot(c.job_ref);
    if (slot < 0) return slot_view(jst_pkg::RS_NOT_FOUND, -1);
    st = job_slots[slot].state;

    case (c.action)
      jst_pkg::ACT_READY: begin
        if (st != jst_pkg::JS_SUBMITTED) return slot_view(jst_pkg::RS_WRONG_STATE, slot);
        job_slots[slot].state = jst_pkg::JS_READY;
      end
      jst_pkg::ACT_CANCEL: begin
        if (job_closed(st)) return slot_view(jst_pkg::RS_WRONG_STATE, slot);
        job_slots[slot].state    = jst_pkg::JS_CANCELLED;
        job_slots[slot].finished = c.now_time;
      end
      jst_pkg::ACT_REEVAL: begin
        // cancelled jobs and empty task sets are left alone
        if (st != jst_pkg::JS_CANCELLED && c.tasks_total != 16'd0) begin
          closed_tasks = {1'b0, c.tasks_done} + {1'b0, c.tasks_failed};
          if (closed_tasks == {1'b0, c.tasks_total}) begin
            if (c.tasks_failed == 16'd0) job_slots[slot].state = jst_pkg::JS_COMPLETED;
            else if (c.tasks_done == 16'd0) job_slots[slot].state = jst_pkg::JS_FAILED;
            else job_slots[slot].state = jst_pkg::JS_PARTIAL;
            if (!job_closed(st)) job_slots[slot].finished = c.now_time;
          end else if (c.tasks_assigned != 16'd0 &&
                       (st == jst_pkg::JS_READY || st == jst_pkg::JS_SUBMITTED)) begin
            job_slots[slot].state = jst_pkg::JS_RUNNING;
            if (job_slots[slot].started == '0) job_slots[slot].started = c.now_time;
          end
        end
      end
      jst_pkg::ACT_REMOVE: begin
        // report the entry as it was, then back-fill from the last slot
        r = slot_view(jst_pkg::RS_OK, slot);
        job_slots[slot] = job_slots[job_count - 1];
        job_count--;
        return r;
      end
      default: ;
    endcase
    return slot_view(jst_pkg::RS_OK, slot);
  endfunction

  task automatic flag_mismatch(input string msg);
    fail_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] exp_val);
    if (got !== exp_val) begin
      flag_mismatch($sformatf("beat %0d %s got 0x%0h want 0x%0h", beat_count, name, got,
                              exp_val));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      job_count   = 0;
      next_number = 32'd1;
      awaited_results.delete();
    end else begin
      // result beat: compare with the oldest prediction
      if (done === 1'b1) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch($sformatf("beat %0d arrived with nothing awaited", beat_count));
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 64'(result.status), 64'(want.status));
          check_field("job_number", 64'(result.job_number), 64'(want.job_number));
          check_field("job_state", 64'(result.job_state), 64'(want.job_state));
          check_field("client_owner", 64'(result.client_owner), 64'(want.client_owner));
          check_field("submit_time", 64'(result.submit_time), 64'(want.submit_time));
          check_field("start_time", 64'(result.start_time), 64'(want.start_time));
          check_field("finish_time", 64'(result.finish_time), 64'(want.finish_time));
        end
        beat_count++;
      end
      // command beat: predict its result
      if (start === 1'b1 && busy === 1'b0) awaited_results.push_back(apply_job_command(cmd));
    end
    pending = awaited_results.size();
  end

endmodule

FILE: tb/tb_job_status_table.sv
`timescale 1ns / 1ps

module tb_job_status_table;

  // codes the block must reject
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS = 1700;
  localparam int CALM_TAIL    = 200;
  localparam int PHASE_LEN    = 200;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 1000000;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             done;
  jst_pkg::cmd_t    cmd;
  jst_pkg::result_t result;
  int               fail_count;
  int               pending;
  int               cycle_count = 0;

  // job numbers believed live, so refs mostly hit
  logic [31:0] live_ids[$];
  logic [31:0] next_number_hint;
  logic [47:0] wall_ms;

  job_status_table i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  job_table_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("job_status_table verification failed");
      $finish;
    end
  end

  function automatic jst_pkg::cmd_t make_cmd(input logic [2:0] action,
                                             input logic [31:0] job_no,
                                             input logic [31:0] tag, input logic [47:0] now,
                                             input logic [15:0] tot, input logic [15:0] ok_n,
                                             input logic [15:0] bad_n,
                                             input logic [15:0] asg_n);
    jst_pkg::cmd_t c;
    c.action         = action;
    c.job_ref        = job_no;
    c.client_tag     = tag;
    c.now_time       = now;
    c.tasks_total    = tot;
    c.tasks_done     = ok_n;
    c.tasks_failed   = bad_n;
    c.tasks_assigned = asg_n;
    return c;
  endfunction

  // one command beat; tracks live numbers for later targeting
  task automatic issue(input jst_pkg::cmd_t c);
    int hits[$];
    if (c.action == jst_pkg::ACT_ADD && live_ids.size() < jst_pkg::MAX_JOBS &&
        next_number_hint != 32'd0) begin
      live_ids.push_back(next_number_hint);
      next_number_hint++;
    end
    if (c.action == jst_pkg::ACT_REMOVE && c.job_ref != 32'd0) begin
      hits = live_ids.find_first_index with (item == c.job_ref);
      if (hits.size() > 0) live_ids.delete(hits[0]);
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // sender gap; command bus carries junk meanwhile
  task automatic pause(input int n);
    logic [255:0] noise;
    repeat (n) begin
      for (int k = 0; k < 8; k++) noise[k*32 +: 32] = $urandom;
      @(negedge clk);
      start <= 1'b0;
      cmd   <= noise[$bits(jst_pkg::cmd_t)-1:0];
    end
  endtask

  function automatic logic [31:0] pick_job();
    int roll;
    roll = $urandom_range(0, 99);
    if (live_ids.size() > 0 && roll < 80) return live_ids[$urandom_range(0, live_ids.size() - 1)];
    if (roll < 86) return 32'd0;
    if (roll < 94) return next_number_hint - $urandom_range(0, 3);
    return $urandom;
  endfunction

  // mostly advancing wall clock, sometimes zero or anything
  function automatic logic [47:0] next_timestamp();
    int          roll;
    logic [63:0] w;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 8) begin
      w = {$urandom, $urandom};
      return w[47:0];
    end
    wall_ms = wall_ms + $urandom_range(1, 5000);
    return wall_ms;
  endfunction

  function automatic jst_pkg::cmd_t reeval_cmd(input logic [31:0] job_no,
                                               input logic [47:0] now);
    logic [15:0] tot, ok_n, bad_n, asg_n;
    int          roll;
    roll  = $urandom_range(0, 99);
    tot   = 16'($urandom_range(1, 12));
    asg_n = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
    ok_n  = '0;
    bad_n = '0;
    if (roll < 8) begin
      tot   = '0;
      ok_n  = 16'($urandom_range(0, 3));
      bad_n = 16'($urandom_range(0, 3));
    end else if (roll < 45) begin
      // all tasks settled
      case ($urandom_range(0, 3))
        0: ok_n = tot;
        1: ok_n = '0;
        default: ok_n = 16'($urandom_range(0, tot));
      endcase
      bad_n = tot - ok_n;
    end else if (roll < 85) begin
      // still in progress
      ok_n  = 16'($urandom_range(0, tot - 1));
      bad_n = 16'($urandom_range(0, tot - 1 - ok_n));
    end else if (roll < 93) begin
      tot   = 16'($urandom);
      ok_n  = 16'($urandom);
      bad_n = 16'($urandom);
      asg_n = 16'($urandom);
    end else begin
      tot   = 16'hFFFF;
      ok_n  = 16'($urandom_range(0, 16'hFFFF));
      bad_n = tot - ok_n;
    end
    return make_cmd(jst_pkg::ACT_REEVAL, job_no, $urandom, now, tot, ok_n, bad_n, asg_n);
  endfunction

  // mode 0 grows the table, 1 churns, 2 drains it
  function automatic logic [2:0] choose_action(input int mode);
    int         weight [3][7] = '{'{45, 10, 5, 15, 5, 17, 3},
                                  '{20, 15, 10, 25, 12, 15, 3},
                                  '{10, 10, 10, 25, 30, 12, 3}};
    logic [2:0] codes [7] = '{jst_pkg::ACT_ADD, jst_pkg::ACT_READY, jst_pkg::ACT_CANCEL,
                              jst_pkg::ACT_REEVAL, jst_pkg::ACT_REMOVE, jst_pkg::ACT_READ,
                              ACT_SPARE_6};
    int         roll;
    roll = $urandom_range(0, 99);
    for (int k = 0; k < 7; k++) begin
      if (roll < weight[mode][k]) begin
        if (codes[k] == ACT_SPARE_6) return $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
        return codes[k];
      end
      roll -= weight[mode][k];
    end
    return jst_pkg::ACT_READ;
  endfunction

  initial begin
    logic [2:0]  act;
    logic [31:0] job_no;
    logic [47:0] now;
    rst              = 1'b1;
    start            = 1'b0;
    cmd              = '0;
    wall_ms          = 48'h0000_0100_0000;
    next_number_hint = 32'd1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, zero ref, field extremes
    issue(make_cmd(jst_pkg::ACT_READ, 32'd1, '0, '0, '0, '0, '0, '0));
    issue(make_cmd(jst_pkg::ACT_CANCEL, 32'd0, '0, 48'd10, '0, '0, '0, '0));
    issue(make_cmd(jst_pkg::ACT_ADD, '0, '0, '0, '0, '0, '0, '0));
    issue(make_cmd(jst_pkg::ACT_ADD, '1, '1, '1, '1, '1, '1, '1));
    issue(make_cmd(jst_pkg::ACT_ADD, 32'd7, 32'h5A5A_A5A5, 48'd1000, '0, '0, '0, '0));
    // undefined codes
    issue(make_cmd(ACT_SPARE_6, 32'd1, '1, 48'd1100, '1, '1, '1, '1));
    issue(make_cmd(ACT_SPARE_7, 32'd2, '0, 48'd1200, '0, '0, '0, '0));
    // ready, then ready again in the wrong state
    issue(make_cmd(jst_pkg::ACT_READY, 32'd1, '0, 48'd1300, '0, '0, '0, '0));
    issue(make_cmd(jst_pkg::ACT_READY, 32'd1, '0, 48'd1400, '0, '0, '0, '0));
    // zero task count, then running, completed, failed
    issue(make_cmd(jst_pkg::ACT_REEVAL, 32'd1, '0, 48'd1500, 16'd0, 16'd0, 16'd0, 16'd5));
    issue(make_cmd(jst_pkg::ACT_REEVAL, 32'd1, '0, 48'd2000, 16'd4, 16'd1, 16'd0, 16'd2));
    issue(make_cmd(jst_pkg::ACT_REEVAL, 32'd1, '0, 48'd2500, 16'd4, 16'd2, 16'd0, 16'd1));
    issue(make_cmd(jst_pkg::ACT_REEVAL, 32'd1, '0, 48'd3000, 16'd4, 16'd4, 16'd0, 16'd0));
    issue(make_cmd(jst_pkg::ACT_REEVAL, 32'd1, '0, 48'd3500, 16'd4, 16'd0, 16'd4, 16'd0));
    // cancel refused on a final job, taken on a submitted one
    issue(make_cmd(jst_pkg::ACT_CANCEL, 32'd1, '0, 48'd3600, '0, '0, '0, '0));
    issue(make_cmd(jst_pkg::ACT_CANCEL, 32'd2, '0, 48'd4000, '0, '0, '0, '0));
    issue(make_cmd(jst_pkg::ACT_REEVAL, 32'd2, '0, 48'd4100, 16'd2, 16'd2, 16'd0, 16'd0));
    // counts whose sum overflows 16 bits are not settled
    issue(make_cmd(jst_pkg::ACT_REEVAL, 32'd3, '0, 48'd4500, 16'd1, 16'h8000, 16'h8001,
                   16'hFFFF));
    issue(make_cmd(jst_pkg::ACT_REEVAL, 32'd3, '0, 48'd5000, 16'd3, 16'd1, 16'd2, 16'd0));
    // remove with back-fill, then remove the last slot
    issue(make_cmd(jst_pkg::ACT_REMOVE, 32'd1, '0, '0, '0, '0, '0, '0));
    issue(make_cmd(jst_pkg::ACT_READ, 32'd1, '0, '0, '0, '0, '0, '0));
    issue(make_cmd(jst_pkg::ACT_READ, 32'd3, '0, '0, '0, '0, '0, '0));
    issue(make_cmd(jst_pkg::ACT_REMOVE, 32'd2, '0, '0, '0, '0, '0, '0));
    issue(make_cmd(jst_pkg::ACT_READ, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0));
    // cancel from ready
    issue(make_cmd(jst_pkg::ACT_ADD, '0, 32'h0000_0044, 48'd5500, '0, '0, '0, '0));
    issue(make_cmd(jst_pkg::ACT_READY, 32'd4, '0, 48'd5600, '0, '0, '0, '0));
    issue(make_cmd(jst_pkg::ACT_CANCEL, 32'd4, '0, 48'd5700, '0, '0, '0, '0));
    // running at time zero leaves start unset, and a later pass does not set it
    issue(make_cmd(jst_pkg::ACT_ADD, '0, 32'h0000_0055, 48'd5800, '0, '0, '0, '0));
    issue(make_cmd(jst_pkg::ACT_REEVAL, 32'd5, '0, 48'd0, 16'd2, 16'd0, 16'd0, 16'd1));
    issue(make_cmd(jst_pkg::ACT_REEVAL, 32'd5, '0, 48'd6000, 16'd2, 16'd1, 16'd0, 16'd1));
    issue(make_cmd(jst_pkg::ACT_CANCEL, 32'd5, '0, 48'd6100, '0, '0, '0, '0));

    // random traffic in grow / churn / drain phases
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 5) == 0) pause($urandom_range(1, 19));
      act    = choose_action((n / PHASE_LEN) % 3);
      job_no = (act == jst_pkg::ACT_ADD) ? 32'($urandom) : pick_job();
      now    = next_timestamp();
      if (act == jst_pkg::ACT_REEVAL) begin
        issue(reeval_cmd(job_no, now));
      end else begin
        issue(make_cmd(act, job_no, $urandom, now, 16'($urandom), 16'($urandom),
                       16'($urandom), 16'($urandom)));
      end
    end

    @(negedge clk);
    start <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("job_status_table verification clean");
    end else begin
      $display("job_status_table verification failed");
    end
    $finish;
  end

endmodule
